### rtl/prep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prep_pkg
// Shared types and constants of the periodic release and mixed EDF picker:
// transaction payloads, slot record, operation codes, sequencer states and
// the shared add/subtract unit interface.
// ----------------------------------------------------------------------------
package prep_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int COUNT_W       = 4;
   localparam int SLOT_W        = 4;
   localparam int TIME_W        = 32;
   localparam int PEND_W        = 16;

   localparam logic [0:0] REG_ACTIVE_TASK_COUNT = 1'b0;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_LOAD   = 2'd1,
      OP_SELECT = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_TDUE,
      ST_TADV,
      ST_TMIN,
      ST_SCMP,
      ST_LOAD,
      ST_FRD,
      ST_FWR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [SLOT_W-1:0] task_slot;
      logic [TIME_W-1:0] now_time;
      logic              slot_valid;
      logic [TIME_W-1:0] slot_period;
      logic [TIME_W-1:0] slot_key;
      logic              slot_is_edf;
      logic              slot_is_server;
      logic [TIME_W-1:0] first_release;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] chosen_task;
      logic              switch_needed;
      logic [TIME_W-1:0] earliest_release;
      logic              reschedule_request;
      logic [TIME_W-1:0] total_releases;
      logic              scan_overrun;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] key;
      logic              is_edf;
      logic              is_server;
      logic [TIME_W-1:0] release_time;
      logic [PEND_W-1:0] pending;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

   typedef struct packed {
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic              sub;
   } alu_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              carry;
   } alu_rsp_type;

endpackage

### rtl/prep_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prep_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module prep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/prep_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prep_addsub
// Shared 32-bit add/subtract unit. Subtract gives a minus b with carry out
// high when no borrow occurred; the top sum bit gives the wrapping order.
// ----------------------------------------------------------------------------
module prep_addsub (
   input  prep_pkg::alu_req_type alu_req,
   output prep_pkg::alu_rsp_type alu_rsp
);

   logic [prep_pkg::TIME_W-1:0] b_opnd;
   logic [prep_pkg::TIME_W:0]   full_sum;

   always_comb begin
      b_opnd   = alu_req.sub ? ~alu_req.b : alu_req.b;
      full_sum = {1'b0, alu_req.a} + {1'b0, b_opnd} + (prep_pkg::TIME_W + 1)'(alu_req.sub);
      alu_rsp.sum   = full_sum[prep_pkg::TIME_W-1:0];
      alu_rsp.carry = full_sum[prep_pkg::TIME_W];
   end

endmodule

### rtl/prep_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prep_csr
// APB-style configuration register block holding the active task count.
// ----------------------------------------------------------------------------
module prep_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [prep_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [prep_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [prep_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output logic [prep_pkg::COUNT_W-1:0]       active_count
);

   logic [prep_pkg::COUNT_W-1:0] active_count_ff;
   logic [prep_pkg::COUNT_W-1:0] active_count_in;
   logic                         hit_count;

   assign hit_count = (paddr[prep_pkg::CSR_ADDR_W-1:2] == prep_pkg::REG_ACTIVE_TASK_COUNT);

   always_comb begin
      active_count_in = active_count_ff;
      if (psel && penable && pwrite && hit_count) begin
         active_count_in = pwdata[prep_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= '0;
      end else begin
         active_count_ff <= active_count_in;
      end
   end

   assign prdata       = hit_count ? prep_pkg::CSR_DATA_W'(active_count_ff) : '0;
   assign pready       = 1'b1;
   assign active_count = active_count_ff;

endmodule

### rtl/periodic_release_and_mixed_edf_picker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_release_and_mixed_edf_picker_core
// Task table with periodic job release and a fixed-priority over EDF picker,
// run by a sequencer around one shared add/subtract unit and a slot RAM.
// ----------------------------------------------------------------------------
// Load writes the slot in ST_LOAD; Finish reads it in ST_FRD and lowers a
// nonzero pending count in ST_FWR, skipped for slot zero. Tick: ST_SETUP, then
// ST_SCAN, ST_TDUE, ST_TADV, ST_TMIN per valid slot; Select: ST_SCAN, ST_SCMP
// per valid slot; empty slots pass in ST_SCAN. One transaction at a time; the
// next is accepted once the result is raised; a stalled result holds ST_DONE.
// Synchronous reset clears slot valid bits, counters and flags; no sweep.
// ----------------------------------------------------------------------------
module periodic_release_and_mixed_edf_picker_core #(
   parameter int MAX_TASKS = prep_pkg::MAX_TASKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  prep_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output prep_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [prep_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [prep_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [prep_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int TW    = prep_pkg::TIME_W;
   localparam int PW    = prep_pkg::PEND_W;
   localparam int CW    = prep_pkg::COUNT_W;

   prep_pkg::state_type    state_ff, state_in;
   prep_pkg::req_type      req_ff, req_in;
   prep_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MAX_TASKS-1:0]   valid_ff, valid_in;
   logic [IDX_W-1:0]       current_ff, current_in;
   logic [TW-1:0]          next_rel_ff, next_rel_in;
   logic                   resched_ff, resched_in;
   logic [TW-1:0]          total_ff, total_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [CW-1:0]          seen_ff, seen_in;
   logic [TW-1:0]          nr_ff, nr_in;
   logic                   due_ff, due_in;
   logic [TW-1:0]          cand_ff, cand_in;
   logic [IDX_W-1:0]       best_ff, best_in;
   logic [TW-1:0]          best_key_ff, best_key_in;
   logic                   have_fp_ff, have_fp_in;
   logic                   have_edf_ff, have_edf_in;
   logic                   sw_ff, sw_in;
   logic                   overrun_ff, overrun_in;

   logic [CW-1:0]          active_count;
   prep_pkg::alu_req_type  alu_req;
   prep_pkg::alu_rsp_type  alu_rsp;
   logic                   ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]       ram_wr_addr, ram_rd_addr;
   prep_pkg::slot_rec_type ram_wr_data, rec;
   logic [prep_pkg::REC_W-1:0] ram_rd_raw;

   logic                   scan_end;
   logic [IDX_W-1:0]       scan_idx;
   logic [IDX_W-1:0]       slot_idx;
   logic                   slot_ok;
   logic                   send_ok;
   logic [TW-1:0]          new_rel;
   logic                   gain_job;

   prep_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .active_count (active_count)
   );

   prep_addsub u_addsub (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   prep_ram #(
      .WIDTH (prep_pkg::REC_W),
      .DEPTH (MAX_TASKS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign rec      = prep_pkg::slot_rec_type'(ram_rd_raw);
   assign scan_idx = scan_ff[IDX_W-1:0];
   assign slot_idx = IDX_W'(req_ff.task_slot);
   assign slot_ok  = (req_ff.task_slot != '0) &&
                     ({28'd0, req_ff.task_slot} < 32'(MAX_TASKS));
   assign scan_end = (seen_ff == active_count) || (scan_ff == CNT_W'(MAX_TASKS));
   assign send_ok  = !rsp_valid_ff || !rsp_stall;
   assign new_rel  = due_ff ? alu_rsp.sum : rec.release_time;
   assign gain_job = due_ff && !rec.is_server;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prep_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.operation)
                  prep_pkg::OP_TICK:   state_in = prep_pkg::ST_SETUP;
                  prep_pkg::OP_LOAD:   state_in = prep_pkg::ST_LOAD;
                  prep_pkg::OP_SELECT: state_in = prep_pkg::ST_SCAN;
                  default:             state_in = prep_pkg::ST_FRD;
               endcase
            end
         end
         prep_pkg::ST_SETUP: state_in = prep_pkg::ST_SCAN;
         prep_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = prep_pkg::ST_DONE;
            end else if (valid_ff[scan_idx]) begin
               state_in = (req_ff.operation == prep_pkg::OP_TICK) ?
                          prep_pkg::ST_TDUE : prep_pkg::ST_SCMP;
            end
         end
         prep_pkg::ST_TDUE: state_in = prep_pkg::ST_TADV;
         prep_pkg::ST_TADV: state_in = prep_pkg::ST_TMIN;
         prep_pkg::ST_TMIN: state_in = prep_pkg::ST_SCAN;
         prep_pkg::ST_SCMP: state_in = prep_pkg::ST_SCAN;
         prep_pkg::ST_LOAD: state_in = prep_pkg::ST_DONE;
         prep_pkg::ST_FRD:  state_in = slot_ok ? prep_pkg::ST_FWR : prep_pkg::ST_DONE;
         prep_pkg::ST_FWR:  state_in = prep_pkg::ST_DONE;
         prep_pkg::ST_DONE: begin
            if (send_ok) begin
               state_in = prep_pkg::ST_IDLE;
            end
         end
         default: state_in = prep_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      valid_in     = valid_ff;
      current_in   = current_ff;
      next_rel_in  = next_rel_ff;
      resched_in   = resched_ff;
      total_in     = total_ff;
      scan_in      = scan_ff;
      seen_in      = seen_ff;
      nr_in        = nr_ff;
      due_in       = due_ff;
      cand_in      = cand_ff;
      best_in      = best_ff;
      best_key_in  = best_key_ff;
      have_fp_in   = have_fp_ff;
      have_edf_in  = have_edf_ff;
      sw_in        = sw_ff;
      overrun_in   = overrun_ff;
      alu_req      = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = scan_idx;
      ram_wr_data  = rec;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_idx;

      unique case (state_ff)
         prep_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               scan_in     = CNT_W'(1);
               seen_in     = '0;
               best_in     = '0;
               best_key_in = '1;
               have_fp_in  = 1'b0;
               have_edf_in = 1'b0;
               sw_in       = 1'b0;
               overrun_in  = 1'b0;
            end
         end
         prep_pkg::ST_SETUP: begin
            alu_req = '{a: req_ff.now_time, b: TW'(1), sub: 1'b0};
            nr_in   = alu_rsp.sum;
         end
         prep_pkg::ST_SCAN: begin
            if (scan_end) begin
               overrun_in = (seen_ff < active_count);
               if (req_ff.operation == prep_pkg::OP_TICK) begin
                  next_rel_in = nr_ff;
               end else begin
                  sw_in      = (best_ff != current_ff);
                  current_in = best_ff;
                  resched_in = 1'b0;
               end
            end else if (valid_ff[scan_idx]) begin
               ram_rd_en = 1'b1;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         prep_pkg::ST_TDUE: begin
            alu_req = '{a: req_ff.now_time, b: rec.release_time, sub: 1'b1};
            due_in  = !alu_rsp.sum[TW-1];
         end
         prep_pkg::ST_TADV: begin
            alu_req                  = '{a: rec.release_time, b: rec.period, sub: 1'b0};
            cand_in                  = new_rel;
            ram_wr_en                = 1'b1;
            ram_wr_data.release_time = new_rel;
            if (gain_job) begin
               if (rec.pending != '1) begin
                  ram_wr_data.pending = rec.pending + PW'(1);
               end
               resched_in = 1'b1;
               total_in   = total_ff + TW'(1);
            end
         end
         prep_pkg::ST_TMIN: begin
            alu_req = '{a: cand_ff, b: nr_ff, sub: 1'b1};
            if ((seen_ff == '0) || alu_rsp.sum[TW-1]) begin
               nr_in = cand_ff;
            end
            seen_in = seen_ff + CW'(1);
            scan_in = scan_ff + CNT_W'(1);
         end
         prep_pkg::ST_SCMP: begin
            alu_req = '{a: rec.key, b: best_key_ff, sub: 1'b1};
            seen_in = seen_ff + CW'(1);
            scan_in = scan_ff + CNT_W'(1);
            if (rec.pending != '0) begin
               if (!rec.is_edf) begin
                  if (!have_fp_ff || !alu_rsp.carry) begin
                     have_fp_in  = 1'b1;
                     best_key_in = rec.key;
                     best_in     = scan_idx;
                  end
               end else if (!have_fp_ff && (!have_edf_ff || alu_rsp.sum[TW-1])) begin
                  have_edf_in = 1'b1;
                  best_key_in = rec.key;
                  best_in     = scan_idx;
               end
            end
         end
         prep_pkg::ST_LOAD: begin
            if (slot_ok) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = slot_idx;
               ram_wr_data = '{period:       req_ff.slot_period,
                               key:          req_ff.slot_key,
                               is_edf:       req_ff.slot_is_edf,
                               is_server:    req_ff.slot_is_server,
                               release_time: req_ff.first_release,
                               pending:      '0};
               valid_in[slot_idx] = req_ff.slot_valid;
            end
         end
         prep_pkg::ST_FRD: begin
            ram_rd_en   = slot_ok;
            ram_rd_addr = slot_idx;
         end
         prep_pkg::ST_FWR: begin
            ram_wr_addr = slot_idx;
            if (rec.pending != '0) begin
               ram_wr_en           = 1'b1;
               ram_wr_data.pending = rec.pending - PW'(1);
            end
         end
         prep_pkg::ST_DONE: begin
            if (send_ok) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{chosen_task:        prep_pkg::SLOT_W'(current_ff),
                          switch_needed:      sw_ff,
                          earliest_release:   next_rel_ff,
                          reschedule_request: resched_ff,
                          total_releases:     total_ff,
                          scan_overrun:       overrun_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prep_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         current_ff   <= '0;
         next_rel_ff  <= '0;
         resched_ff   <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         current_ff   <= current_in;
         next_rel_ff  <= next_rel_in;
         resched_ff   <= resched_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      scan_ff     <= scan_in;
      seen_ff     <= seen_in;
      nr_ff       <= nr_in;
      due_ff      <= due_in;
      cand_ff     <= cand_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      have_fp_ff  <= have_fp_in;
      have_edf_ff <= have_edf_in;
      sw_ff       <= sw_in;
      overrun_ff  <= overrun_in;
   end

   assign req_stall = (state_ff != prep_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != prep_pkg::ST_IDLE))
      else $error("sequencer idle after accepted transaction");

   a_idle_slot_never_valid : assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0])
      else $error("idle slot marked valid");

   a_result_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == prep_pkg::ST_DONE))
      else $error("result raised outside completion state");

   a_seen_bounded : assert property (@(posedge clock) disable iff (reset)
      (state_ff == prep_pkg::ST_SCAN) |-> (seen_ff <= active_count))
      else $error("scan visited more slots than the active count");

endmodule

### tb/periodic_release_and_mixed_edf_picker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_release_and_mixed_edf_picker_core_tb
// Self-checking bench for the periodic release and mixed EDF picker. Plain
// tasks drive request transactions and APB writes of the task count. A
// scoreboard keeps its own copy of the task table and works out each
// response as requests are accepted. The first part is a short directed run
// over the empty table, slot zero, overrun, wrap and priority order. The
// random part runs in phases at several task counts with random gaps and
// stalls, and one phase has no idling at all.
// ----------------------------------------------------------------------------
module periodic_release_and_mixed_edf_picker_core_tb;

   localparam int TASK_SLOTS  = prep_pkg::MAX_TASKS_DEF;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int PHASE_ITEMS = 210;
   localparam int IDLE_PCT    = 19;
   localparam int TAIL_CYCLES = 80;
   localparam logic [prep_pkg::SLOT_W-1:0] IDLE_SLOT = '0;
   localparam logic [prep_pkg::CSR_ADDR_W-1:0] TASK_COUNT_ADDR =
      prep_pkg::CSR_ADDR_W'(4 * prep_pkg::REG_ACTIVE_TASK_COUNT);

   class sched_scoreboard;
      logic [prep_pkg::COUNT_W-1:0] task_count;
      logic                         valid_bit  [TASK_SLOTS];
      logic [prep_pkg::TIME_W-1:0]  period     [TASK_SLOTS];
      logic [prep_pkg::TIME_W-1:0]  key        [TASK_SLOTS];
      logic                         edf_bit    [TASK_SLOTS];
      logic                         server_bit [TASK_SLOTS];
      logic [prep_pkg::TIME_W-1:0]  release_at [TASK_SLOTS];
      logic [prep_pkg::PEND_W-1:0]  jobs       [TASK_SLOTS];
      logic [prep_pkg::SLOT_W-1:0]  running;
      logic [prep_pkg::TIME_W-1:0]  release_mark;
      logic                         resched;
      logic [prep_pkg::TIME_W-1:0]  released;
      prep_pkg::rsp_type            awaited [$];
      int                           errors;

      function new();
         task_count   = '0;
         running      = IDLE_SLOT;
         release_mark = '0;
         resched      = 1'b0;
         released     = '0;
         errors       = 0;
         for (int s = 0; s < TASK_SLOTS; s++) begin
            valid_bit[s]  = 1'b0;
            period[s]     = '0;
            key[s]        = '0;
            edf_bit[s]    = 1'b0;
            server_bit[s] = 1'b0;
            release_at[s] = '0;
            jobs[s]       = '0;
         end
      endfunction

      task report(string msg);
         errors++;
         $display("%0t: %s", $realtime, msg);
      endtask

      function logic release_tick(logic [prep_pkg::TIME_W-1:0] now);
         int unsigned                 seen;
         logic [prep_pkg::TIME_W-1:0] nearest;
         logic [prep_pkg::TIME_W-1:0] lag;
         seen    = 0;
         nearest = now + 1;
         for (int s = 1; s < TASK_SLOTS && seen < task_count; s++) begin
            if (!valid_bit[s]) continue;
            lag = now - release_at[s];
            if (!lag[prep_pkg::TIME_W-1]) begin
               release_at[s] += period[s];
               if (!server_bit[s]) begin
                  if (jobs[s] != '1) jobs[s]++;
                  resched = 1'b1;
                  released++;
               end
            end
            lag = release_at[s] - nearest;
            if (seen == 0 || lag[prep_pkg::TIME_W-1]) nearest = release_at[s];
            seen++;
         end
         release_mark = nearest;
         return seen < task_count;
      endfunction

      function logic pick_winner(output logic [prep_pkg::SLOT_W-1:0] winner);
         int unsigned                 seen;
         logic [prep_pkg::TIME_W-1:0] best_key;
         logic [prep_pkg::TIME_W-1:0] lag;
         logic                        have_fp;
         logic                        have_edf;
         seen     = 0;
         best_key = '1;
         have_fp  = 1'b0;
         have_edf = 1'b0;
         winner   = IDLE_SLOT;
         for (int s = 1; s < TASK_SLOTS && seen < task_count; s++) begin
            if (!valid_bit[s]) continue;
            seen++;
            if (jobs[s] == '0) continue;
            if (!edf_bit[s]) begin
               if (!have_fp || key[s] < best_key) begin
                  have_fp  = 1'b1;
                  best_key = key[s];
                  winner   = prep_pkg::SLOT_W'(s);
               end
            end else if (!have_fp) begin
               lag = key[s] - best_key;
               if (!have_edf || lag[prep_pkg::TIME_W-1]) begin
                  have_edf = 1'b1;
                  best_key = key[s];
                  winner   = prep_pkg::SLOT_W'(s);
               end
            end
         end
         return seen < task_count;
      endfunction

      function void note_request(prep_pkg::req_type r);
         prep_pkg::rsp_type           outcome;
         logic [prep_pkg::SLOT_W-1:0] winner;
         outcome = '0;
         case (prep_pkg::op_type'(r.operation))
            prep_pkg::OP_TICK: begin
               outcome.scan_overrun = release_tick(r.now_time);
            end
            prep_pkg::OP_LOAD: begin
               if (r.task_slot != IDLE_SLOT) begin
                  valid_bit[r.task_slot]  = r.slot_valid;
                  period[r.task_slot]     = r.slot_period;
                  key[r.task_slot]        = r.slot_key;
                  edf_bit[r.task_slot]    = r.slot_is_edf;
                  server_bit[r.task_slot] = r.slot_is_server;
                  release_at[r.task_slot] = r.first_release;
                  jobs[r.task_slot]       = '0;
               end
            end
            prep_pkg::OP_SELECT: begin
               outcome.scan_overrun  = pick_winner(winner);
               outcome.switch_needed = winner != running;
               running = winner;
               resched = 1'b0;
            end
            prep_pkg::OP_FINISH: begin
               if (r.task_slot != IDLE_SLOT && jobs[r.task_slot] != '0)
                  jobs[r.task_slot]--;
            end
         endcase
         outcome.chosen_task        = running;
         outcome.earliest_release   = release_mark;
         outcome.reschedule_request = resched;
         outcome.total_releases     = released;
         awaited.push_back(outcome);
      endfunction

      task compare_field(string name, logic [prep_pkg::TIME_W-1:0] got,
                         logic [prep_pkg::TIME_W-1:0] want);
         if (got !== want)
            report($sformatf("%s mismatch: got %0h want %0h", name, got, want));
      endtask

      task check_response(prep_pkg::rsp_type got);
         prep_pkg::rsp_type want;
         if (awaited.size() == 0) begin
            report($sformatf("response with nothing outstanding: %h", got));
            return;
         end
         want = awaited.pop_front();
         compare_field("chosen_task", prep_pkg::TIME_W'(got.chosen_task),
                       prep_pkg::TIME_W'(want.chosen_task));
         compare_field("switch_needed", prep_pkg::TIME_W'(got.switch_needed),
                       prep_pkg::TIME_W'(want.switch_needed));
         compare_field("earliest_release", got.earliest_release, want.earliest_release);
         compare_field("reschedule_request", prep_pkg::TIME_W'(got.reschedule_request),
                       prep_pkg::TIME_W'(want.reschedule_request));
         compare_field("total_releases", got.total_releases, want.total_releases);
         compare_field("scan_overrun", prep_pkg::TIME_W'(got.scan_overrun),
                       prep_pkg::TIME_W'(want.scan_overrun));
      endtask
   endclass

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   prep_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   prep_pkg::rsp_type               rsp_data;
   logic                            psel      = 1'b0;
   logic                            penable   = 1'b0;
   logic                            pwrite    = 1'b0;
   logic [prep_pkg::CSR_ADDR_W-1:0] paddr     = '0;
   logic [prep_pkg::CSR_DATA_W-1:0] pwdata    = '0;
   logic [prep_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   sched_scoreboard             sb = new();
   bit                          calm = 1'b0;
   logic [prep_pkg::TIME_W-1:0] sim_now = '0;
   int unsigned                 cycle_count = 0;

   periodic_release_and_mixed_edf_picker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
   end

   function automatic prep_pkg::req_type blank_req(prep_pkg::op_type op,
                                                   logic [prep_pkg::SLOT_W-1:0] slot);
      prep_pkg::req_type r;
      r.operation      = op;
      r.task_slot      = slot;
      r.now_time       = $urandom;
      r.slot_valid     = 1'($urandom_range(0, 1));
      r.slot_period    = $urandom;
      r.slot_key       = $urandom;
      r.slot_is_edf    = 1'($urandom_range(0, 1));
      r.slot_is_server = 1'($urandom_range(0, 1));
      r.first_release  = $urandom;
      return r;
   endfunction

   function automatic prep_pkg::req_type tick_req(logic [prep_pkg::TIME_W-1:0] now);
      prep_pkg::req_type r;
      r = blank_req(prep_pkg::OP_TICK,
                    prep_pkg::SLOT_W'($urandom_range(0, TASK_SLOTS - 1)));
      r.now_time = now;
      return r;
   endfunction

   function automatic prep_pkg::req_type load_req(logic [prep_pkg::SLOT_W-1:0] slot,
                                                  logic valid,
                                                  logic [prep_pkg::TIME_W-1:0] per,
                                                  logic [prep_pkg::TIME_W-1:0] k,
                                                  logic edf, logic server,
                                                  logic [prep_pkg::TIME_W-1:0] first);
      prep_pkg::req_type r;
      r = blank_req(prep_pkg::OP_LOAD, slot);
      r.slot_valid     = valid;
      r.slot_period    = per;
      r.slot_key       = k;
      r.slot_is_edf    = edf;
      r.slot_is_server = server;
      r.first_release  = first;
      return r;
   endfunction

   function automatic prep_pkg::req_type random_request();
      prep_pkg::req_type r;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         r = blank_req(prep_pkg::op_type'($urandom_range(0, 3)),
                       prep_pkg::SLOT_W'($urandom_range(0, TASK_SLOTS - 1)));
      end else if (pick < 45) begin
         sim_now += $urandom_range(0, 4);
         r = tick_req(sim_now);
      end else if (pick < 65) begin
         r = blank_req(prep_pkg::OP_LOAD,
                       prep_pkg::SLOT_W'($urandom_range(1, TASK_SLOTS - 1)));
         r.slot_valid     = $urandom_range(0, 9) != 0;
         r.slot_is_server = $urandom_range(0, 4) == 0;
         if ($urandom_range(0, 19) != 0) r.slot_period = $urandom_range(0, 12);
         if ($urandom_range(0, 9) != 0) r.first_release = sim_now + $urandom_range(0, 10);
         if ($urandom_range(0, 9) != 0) begin
            if (r.slot_is_edf) r.slot_key = sim_now + $urandom_range(0, 40);
            else r.slot_key = $urandom_range(0, 15);
         end
      end else if (pick < 85) begin
         r = blank_req(prep_pkg::OP_SELECT,
                       prep_pkg::SLOT_W'($urandom_range(0, TASK_SLOTS - 1)));
      end else begin
         r = blank_req(prep_pkg::OP_FINISH,
                       prep_pkg::SLOT_W'($urandom_range(0, TASK_SLOTS - 1)));
      end
      return r;
   endfunction

   task automatic send_request(prep_pkg::req_type r);
      int unsigned gap;
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic drain();
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic apb_cycle(input logic is_write,
                            input logic [prep_pkg::CSR_DATA_W-1:0] wdata,
                            output logic [prep_pkg::CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= TASK_COUNT_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_task_count(logic [prep_pkg::COUNT_W-1:0] value);
      logic [prep_pkg::CSR_DATA_W-1:0] rd;
      apb_cycle(1'b1, prep_pkg::CSR_DATA_W'(value), rd);
      sb.task_count = value;
      apb_cycle(1'b0, '0, rd);
      if (rd !== prep_pkg::CSR_DATA_W'(value))
         sb.report($sformatf("task count readback: got %0h want %0h", rd, value));
   endtask

   int unsigned phase_counts [8] = '{15, 0, 15, 1, 7, 15, 3, 12};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_request(blank_req(prep_pkg::OP_FINISH, 5));
      send_request(tick_req('0));
      send_request(blank_req(prep_pkg::OP_SELECT, IDLE_SLOT));
      send_request(tick_req('1));
      req_valid <= 1'b0;
      drain();
      write_task_count(15);
      send_request(tick_req(7));
      send_request(load_req(IDLE_SLOT, 1'b1, '1, '1, 1'b1, 1'b1, '1));
      send_request(load_req(1, 1'b1, 10, 5, 1'b0, 1'b0, '0));
      send_request(load_req(2, 1'b1, '1, 100, 1'b1, 1'b0, '0));
      send_request(load_req(3, 1'b1, 3, '0, 1'b0, 1'b1, '0));
      send_request(load_req(15, 1'b1, '0, '1, 1'b0, 1'b0, '1));
      send_request(tick_req('0));
      send_request(blank_req(prep_pkg::OP_SELECT, 3));
      send_request(blank_req(prep_pkg::OP_FINISH, 1));
      send_request(blank_req(prep_pkg::OP_SELECT, 0));
      send_request(blank_req(prep_pkg::OP_FINISH, 15));
      send_request(blank_req(prep_pkg::OP_FINISH, 15));
      send_request(blank_req(prep_pkg::OP_SELECT, 15));
      send_request(load_req(4, 1'b1, 1, 50, 1'b1, 1'b0, '0));
      send_request(load_req(5, 1'b1, 1, 32'hFFFF_FFF0, 1'b1, 1'b0, '0));
      send_request(tick_req('0));
      send_request(blank_req(prep_pkg::OP_SELECT, 2));
      send_request(blank_req(prep_pkg::OP_SELECT, 2));
      send_request(blank_req(prep_pkg::OP_FINISH, IDLE_SLOT));

      foreach (phase_counts[p]) begin
         req_valid <= 1'b0;
         drain();
         write_task_count(prep_pkg::COUNT_W'(phase_counts[p]));
         calm = (p == 2);
         if (p == 5) sim_now = 32'hFFFF_FFC0;
         repeat (PHASE_ITEMS) send_request(random_request());
      end

      req_valid <= 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
